@@ sv/epaper_refresh_sequencer_assert.svh @@
// Assertion macros shared by the e-paper refresh sequencer modules.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef EPAPER_REFRESH_SEQUENCER_ASSERT_SVH
`define EPAPER_REFRESH_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/eprs_pkg.sv @@
// Package for the e-paper refresh sequencer: payload types, codes,
// byte script table and frame size clamp. No dependencies.
package eprs_pkg;

  localparam logic [2:0] CMD_BEGIN   = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_REFRESH = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_ABORT   = 3'd4;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_PEND = 3'd1;
  localparam logic [2:0] ST_DONE = 3'd2;
  localparam logic [2:0] ST_ERR  = 3'd3;
  localparam logic [2:0] ST_IDLE = 3'd4;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_IMAGE   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  // Byte script layout: start positions of the fixed sequences.
  localparam logic [4:0] SCR_POWER_ON  = 5'd0;   // 06, 17 x3, 04
  localparam logic [4:0] SCR_POLL      = 5'd3;   // 71, then panel configure
  localparam logic [4:0] SCR_REFRESH   = 5'd16;  // 12
  localparam logic [4:0] SCR_POWER_OFF = 5'd17;  // 71, 50, F7, 02
  localparam logic [4:0] SCR_SLEEP     = 5'd21;  // 71, 07, A5
  localparam logic [4:0] SCR_WRITE     = 5'd24;  // image byte from the item
  localparam int         SCR_LEN       = 25;

  localparam logic [4:0] N_BEGIN_READY = 5'd16;
  localparam logic [4:0] N_BEGIN_WAIT  = 5'd4;
  localparam logic [4:0] N_POLL_READY  = 5'd13;
  localparam logic [4:0] N_ONE         = 5'd1;
  localparam logic [4:0] N_POWER_OFF   = 5'd4;
  localparam logic [4:0] N_SLEEP       = 5'd3;
  localparam logic [4:0] N_NONE        = 5'd0;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       busy_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [12:0] repeat_count;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // One item's worth of output: a run of script entries, then a status.
  typedef struct packed {
    logic [4:0] start;
    logic [4:0] nbytes;
    logic [2:0] status;
    logic [7:0] data_byte;
  } desc_t;

  function automatic logic [12:0] frame_size(input logic [12:0] n, input logic [12:0] cap);
    logic [12:0] v;
    v = (n > cap) ? cap : n;
    if (v == 13'd0) v = 13'd1;
    return v;
  endfunction

  function automatic out_item_t byte_item(input logic [1:0] kind, input logic [7:0] b,
                                          input logic [12:0] rep);
    out_item_t r;
    r.kind         = kind;
    r.out_byte     = b;
    r.repeat_count = rep;
    r.status       = ST_OK;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic out_item_t script_entry(input logic [4:0] idx, input logic [7:0] width,
                                             input logic [7:0] height,
                                             input logic [12:0] fsize,
                                             input logic [7:0] data_byte);
    out_item_t r;
    case (idx)
      5'd0:  r = byte_item(KIND_CMD,  8'h06, 13'd1);
      5'd1:  r = byte_item(KIND_DATA, 8'h17, 13'd3);
      5'd2:  r = byte_item(KIND_CMD,  8'h04, 13'd1);
      5'd3:  r = byte_item(KIND_CMD,  8'h71, 13'd1);
      5'd4:  r = byte_item(KIND_CMD,  8'h00, 13'd1);
      5'd5:  r = byte_item(KIND_DATA, 8'h13, 13'd1);
      5'd6:  r = byte_item(KIND_DATA, 8'h0D, 13'd1);
      5'd7:  r = byte_item(KIND_CMD,  8'h61, 13'd1);
      5'd8:  r = byte_item(KIND_DATA, width, 13'd1);
      5'd9:  r = byte_item(KIND_DATA, 8'h00, 13'd1);
      5'd10: r = byte_item(KIND_DATA, height, 13'd1);
      5'd11: r = byte_item(KIND_CMD,  8'h50, 13'd1);
      5'd12: r = byte_item(KIND_DATA, 8'h97, 13'd1);
      5'd13: r = byte_item(KIND_CMD,  8'h10, 13'd1);
      5'd14: r = byte_item(KIND_DATA, 8'hFF, fsize);
      5'd15: r = byte_item(KIND_CMD,  8'h13, 13'd1);
      5'd16: r = byte_item(KIND_CMD,  8'h12, 13'd1);
      5'd17: r = byte_item(KIND_CMD,  8'h71, 13'd1);
      5'd18: r = byte_item(KIND_CMD,  8'h50, 13'd1);
      5'd19: r = byte_item(KIND_DATA, 8'hF7, 13'd1);
      5'd20: r = byte_item(KIND_CMD,  8'h02, 13'd1);
      5'd21: r = byte_item(KIND_CMD,  8'h71, 13'd1);
      5'd22: r = byte_item(KIND_CMD,  8'h07, 13'd1);
      5'd23: r = byte_item(KIND_DATA, 8'hA5, 13'd1);
      5'd24: r = byte_item(KIND_DATA, data_byte, 13'd1);
      default: r = byte_item(KIND_CMD, 8'h00, 13'd1);
    endcase
    return r;
  endfunction

endpackage

@@ sv/eprs_ctrl.sv @@
// Session state machine of the e-paper refresh sequencer: takes input
// transfers, updates session state, hands one output descriptor per item.
// Depends on eprs_pkg and epaper_refresh_sequencer_assert.svh.
`include "epaper_refresh_sequencer_assert.svh"

module eprs_ctrl #(
  parameter int POWER_TIMEOUT_MS = 5000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  eprs_pkg::in_item_t in_data,
  input  logic [12:0]       frame_sz,
  input  logic [19:0]       refr_limit,
  input  logic              desc_take,
  output logic              desc_valid,
  output eprs_pkg::desc_t   desc
);
  import eprs_pkg::*;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_PWAIT = 3'd1,
    MODE_LOAD  = 3'd2,
    MODE_REFR  = 3'd3,
    MODE_POFF  = 3'd4
  } mode_t;

  localparam logic [12:0] PWR_LIMIT = 13'(POWER_TIMEOUT_MS);
  localparam logic [6:0]  REFR_MIN  = 7'd100;
  localparam logic [6:0]  POFF_MIN  = 7'd1;

  mode_t       mode_r, mode_nxt;
  logic [12:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [12:0] pwr_ticks_r, pwr_ticks_nxt;
  logic [6:0]  phase_r, phase_nxt;
  logic [19:0] refr_ticks_r, refr_ticks_nxt;
  desc_t       desc_nxt;
  logic        accept;
  logic        go_off;

  assign in_stall   = !desc_take;
  assign accept     = in_valid && desc_take;
  assign desc_valid = accept;
  assign desc       = desc_nxt;

  always_comb begin
    mode_nxt       = mode_r;
    rcv_cnt_nxt    = rcv_cnt_r;
    pwr_ticks_nxt  = pwr_ticks_r;
    phase_nxt      = phase_r;
    refr_ticks_nxt = refr_ticks_r;
    go_off         = 1'b0;
    desc_nxt.start     = SCR_WRITE;
    desc_nxt.nbytes    = N_NONE;
    desc_nxt.status    = ST_ERR;
    desc_nxt.data_byte = in_data.data_byte;
    case (in_data.command)
      CMD_BEGIN: begin
        if (mode_r == MODE_OFF) begin
          desc_nxt.start = SCR_POWER_ON;
          if (in_data.busy_level) begin
            desc_nxt.nbytes  = N_BEGIN_READY;
            desc_nxt.status  = ST_OK;
            mode_nxt         = MODE_LOAD;
            rcv_cnt_nxt      = '0;
            pwr_ticks_nxt    = '0;
          end else if (PWR_LIMIT == 13'd0) begin
            desc_nxt.nbytes = N_BEGIN_WAIT;
            go_off          = 1'b1;
          end else begin
            desc_nxt.nbytes = N_BEGIN_WAIT;
            desc_nxt.status = ST_PEND;
            mode_nxt        = MODE_PWAIT;
            rcv_cnt_nxt     = '0;
            pwr_ticks_nxt   = '0;
          end
        end else begin
          go_off = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (mode_r == MODE_LOAD && rcv_cnt_r < frame_sz) begin
          desc_nxt.start  = SCR_WRITE;
          desc_nxt.nbytes = N_ONE;
          desc_nxt.status = ST_OK;
          rcv_cnt_nxt     = rcv_cnt_r + 13'd1;
        end else begin
          go_off = 1'b1;
        end
      end
      CMD_REFRESH: begin
        if (mode_r == MODE_LOAD && rcv_cnt_r == frame_sz) begin
          desc_nxt.start  = SCR_REFRESH;
          desc_nxt.nbytes = N_ONE;
          desc_nxt.status = ST_OK;
          mode_nxt        = MODE_REFR;
          phase_nxt       = '0;
          refr_ticks_nxt  = '0;
        end else begin
          go_off = 1'b1;
        end
      end
      CMD_TICK: begin
        case (mode_r)
          MODE_OFF:  desc_nxt.status = ST_IDLE;
          MODE_LOAD: desc_nxt.status = ST_OK;
          MODE_PWAIT: begin
            // Count the tick, saturating, then poll busy again.
            if (pwr_ticks_r != 13'h1FFF) pwr_ticks_nxt = pwr_ticks_r + 13'd1;
            desc_nxt.start = SCR_POLL;
            if (in_data.busy_level) begin
              desc_nxt.nbytes = N_POLL_READY;
              desc_nxt.status = ST_OK;
              mode_nxt        = MODE_LOAD;
              rcv_cnt_nxt     = '0;
            end else if (pwr_ticks_nxt >= PWR_LIMIT) begin
              desc_nxt.nbytes = N_ONE;
              go_off          = 1'b1;
            end else begin
              desc_nxt.nbytes = N_ONE;
              desc_nxt.status = ST_PEND;
            end
          end
          default: begin
            if (refr_ticks_r != 20'hFFFFF) refr_ticks_nxt = refr_ticks_r + 20'd1;
            if (phase_r != 7'h7F) phase_nxt = phase_r + 7'd1;
            if (refr_ticks_nxt >= refr_limit) begin
              go_off = 1'b1;
            end else if (phase_nxt < ((mode_r == MODE_POFF) ? POFF_MIN : REFR_MIN)) begin
              desc_nxt.status = ST_PEND;
            end else if (!in_data.busy_level) begin
              desc_nxt.start  = SCR_POWER_OFF;
              desc_nxt.nbytes = N_ONE;
              desc_nxt.status = ST_PEND;
            end else if (mode_r == MODE_REFR) begin
              desc_nxt.start  = SCR_POWER_OFF;
              desc_nxt.nbytes = N_POWER_OFF;
              desc_nxt.status = ST_PEND;
              mode_nxt        = MODE_POFF;
              phase_nxt       = '0;
            end else begin
              desc_nxt.start  = SCR_SLEEP;
              desc_nxt.nbytes = N_SLEEP;
              desc_nxt.status = ST_DONE;
              go_off          = 1'b1;
            end
          end
        endcase
      end
      CMD_ABORT: begin
        go_off          = 1'b1;
        desc_nxt.status = ST_IDLE;
      end
      default: go_off = 1'b1;
    endcase
    if (go_off) begin
      mode_nxt       = MODE_OFF;
      rcv_cnt_nxt    = '0;
      pwr_ticks_nxt  = '0;
      phase_nxt      = '0;
      refr_ticks_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OFF;
      rcv_cnt_r    <= '0;
      pwr_ticks_r  <= '0;
      phase_r      <= '0;
      refr_ticks_r <= '0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      rcv_cnt_r    <= rcv_cnt_nxt;
      pwr_ticks_r  <= pwr_ticks_nxt;
      phase_r      <= phase_nxt;
      refr_ticks_r <= refr_ticks_nxt;
    end
  end

  `EPRS_ASSERT_NOW(a_off_clear, mode_r == MODE_OFF,
    rcv_cnt_r == 13'd0 && pwr_ticks_r == 13'd0 && phase_r == 7'd0 && refr_ticks_r == 20'd0,
    "counters not cleared while off")
  `EPRS_ASSERT_NOW(a_load_no_refresh, mode_r == MODE_LOAD,
    phase_r == 7'd0 && refr_ticks_r == 20'd0, "refresh counters live while loading")
  `EPRS_ASSERT_NEXT(a_abort_off, accept && in_data.command == CMD_ABORT,
    mode_r == MODE_OFF, "abort did not return to off")

endmodule

@@ sv/eprs_emit.sv @@
// Result sequencer of the e-paper refresh sequencer: walks one descriptor
// through the byte script, then the status, into the output register.
// Depends on eprs_pkg and epaper_refresh_sequencer_assert.svh.
`include "epaper_refresh_sequencer_assert.svh"

module eprs_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               desc_valid,
  input  eprs_pkg::desc_t    desc,
  output logic               desc_take,
  input  logic [7:0]         panel_width,
  input  logic [7:0]         panel_height,
  input  logic [12:0]        frame_sz,
  output logic               out_valid,
  input  logic               out_stall,
  output eprs_pkg::out_item_t out_data
);
  import eprs_pkg::*;

  logic       pend_r, pend_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [2:0] status_r, status_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  out_item_t  stat_item;
  logic       out_free;
  logic       emit;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = pend_r && out_free;
  assign desc_take = !pend_r || (emit && cnt_r == 5'd0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat_item.kind         = KIND_STAT;
    stat_item.out_byte     = 8'h00;
    stat_item.repeat_count = 13'd1;
    stat_item.status       = status_r;
    stat_item.last         = 1'b1;

    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (cnt_r != 5'd0) begin
        out_data_nxt = script_entry(idx_r, panel_width, panel_height, frame_sz, byte_r);
        idx_nxt      = idx_r + 5'd1;
        cnt_nxt      = cnt_r - 5'd1;
      end else begin
        out_data_nxt = stat_item;
        pend_nxt     = 1'b0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // A new descriptor lands only when the slot is free or just drained.
    if (desc_valid) begin
      pend_nxt   = 1'b1;
      idx_nxt    = desc.start;
      cnt_nxt    = desc.nbytes;
      status_nxt = desc.status;
      byte_nxt   = desc.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
  end

  `EPRS_ASSERT_NOW(a_desc_when_free, desc_valid, desc_take,
    "descriptor offered while one is still pending")
  `EPRS_ASSERT_NOW(a_script_bound, pend_r,
    ({1'b0, idx_r} + {1'b0, cnt_r}) <= 6'(SCR_LEN), "script run past table end")
  `EPRS_ASSERT_NEXT(a_status_drains, emit && cnt_r == 5'd0 && !desc_valid,
    !pend_r && out_valid_r && out_data_r.last, "status transfer did not close the item")

endmodule

@@ sv/epaper_refresh_sequencer.sv @@
// Top level of the e-paper refresh sequencer: configuration registers,
// frame size clamp, session control and result sequencer.
// Depends on eprs_pkg, eprs_ctrl, eprs_emit.
//
// - Input channel (in_valid / in_stall / in_data): one event per transfer
//   (begin, write_byte, refresh_start, tick, abort) with the sampled busy
//   level. Session state updates at the input transfer.
// - Output channel (out_valid / out_stall / out_data): command and data bytes
//   for the serial link, then one status result with last set. A white fill
//   is one data result whose repeat_count is the frame size.
// - Each descriptor is registered in the result sequencer, then each result in the
//   output register. An item yields 1 to 17 results at one per cycle while
//   out_stall is low; the next item is taken as the status enters the output
//   register, so status-only items (such as ticks while off) flow at one per cycle.
// - Out_stall holds the output register and, once the descriptor slot is
//   full, raises in_stall. Configuration writes (cfg_we/cfg_addr/cfg_wdata)
//   land at any edge; make them only while no item is in flight.
// - Synchronous reset: session off, counters zero, registers to their
//   defaults (104, 212, 2756, 40000), both channels empty.
module epaper_refresh_sequencer #(
  parameter int MAX_IMAGE_BYTES  = 4096,
  parameter int POWER_TIMEOUT_MS = 5000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  eprs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output eprs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [19:0]        cfg_wdata
);
  import eprs_pkg::*;

  // Frame size cap: the smaller of the parameter and the 13-bit limit.
  localparam int          CAP_INT   = (MAX_IMAGE_BYTES < 8191) ? MAX_IMAGE_BYTES : 8191;
  localparam logic [12:0] FRAME_CAP = 13'(CAP_INT);

  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [12:0] image_r;
  logic [19:0] timeout_r;
  logic [12:0] frame_sz;
  logic        desc_take;
  logic        desc_valid;
  desc_t       desc;

  // Register file: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 8'd104;
      height_r  <= 8'd212;
      image_r   <= 13'd2756;
      timeout_r <= 20'd40000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH:   width_r   <= cfg_wdata[7:0];
        CFG_HEIGHT:  height_r  <= cfg_wdata[7:0];
        CFG_IMAGE:   image_r   <= cfg_wdata[12:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into 1 .. cap; used for the fill count and checks.
  assign frame_sz = frame_size(image_r, FRAME_CAP);

  eprs_ctrl #(
    .POWER_TIMEOUT_MS(POWER_TIMEOUT_MS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .frame_sz   (frame_sz),
    .refr_limit (timeout_r),
    .desc_take  (desc_take),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  eprs_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .desc_valid   (desc_valid),
    .desc         (desc),
    .desc_take    (desc_take),
    .panel_width  (width_r),
    .panel_height (height_r),
    .frame_sz     (frame_sz),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

@@ dv/tb.sv @@
// Testbench for epaper_refresh_sequencer: directed and random session traffic with
// random idling on both channels, checked result by result against a built-in predictor.
// Depends on eprs_pkg and the epaper_refresh_sequencer RTL.
module tb;
  import eprs_pkg::*;

  localparam int MAX_IMAGE_BYTES  = 4096;
  localparam int POWER_TIMEOUT_MS = 5000;
  localparam int FRAME_CAP        = (MAX_IMAGE_BYTES < 8191) ? MAX_IMAGE_BYTES : 8191;

  localparam int REFRESH_MIN_TICKS  = 100;
  localparam int POWEROFF_MIN_TICKS = 1;

  localparam int RESET_CYCLES  = 5;
  localparam int WAIT_MAX      = 11;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_QUIET     = 20;
  localparam int MAX_RESULTS   = 17;
  localparam int REPORT_MAX    = 40;
  localparam int RANDOM_ITEMS  = 90;
  localparam int PHASE_ITEMS   = 50;

  localparam logic [7:0]  WIDTH_RESET   = 8'd104;
  localparam logic [7:0]  HEIGHT_RESET  = 8'd212;
  localparam logic [12:0] IMAGE_RESET   = 13'd2756;
  localparam logic [19:0] TIMEOUT_RESET = 20'd40000;

  // Panel command opcodes and fixed data bytes on the serial link.
  localparam logic [7:0] PCMD_PANEL_SETTING  = 8'h00;
  localparam logic [7:0] PCMD_POWER_OFF      = 8'h02;
  localparam logic [7:0] PCMD_POWER_ON       = 8'h04;
  localparam logic [7:0] PCMD_BOOSTER        = 8'h06;
  localparam logic [7:0] PCMD_DEEP_SLEEP     = 8'h07;
  localparam logic [7:0] PCMD_OLD_IMAGE      = 8'h10;
  localparam logic [7:0] PCMD_REFRESH        = 8'h12;
  localparam logic [7:0] PCMD_NEW_IMAGE      = 8'h13;
  localparam logic [7:0] PCMD_VCOM_INTERVAL  = 8'h50;
  localparam logic [7:0] PCMD_RESOLUTION     = 8'h61;
  localparam logic [7:0] PCMD_GET_STATUS     = 8'h71;
  localparam logic [7:0] BOOSTER_BYTE        = 8'h17;
  localparam logic [7:0] PSR_BYTE_0          = 8'h13;
  localparam logic [7:0] PSR_BYTE_1          = 8'h0D;
  localparam logic [7:0] VCOM_LOAD_BYTE      = 8'h97;
  localparam logic [7:0] VCOM_SLEEP_BYTE     = 8'hF7;
  localparam logic [7:0] SLEEP_KEY_BYTE      = 8'hA5;
  localparam logic [7:0] WHITE_BYTE          = 8'hFF;
  localparam logic [12:0] BOOSTER_REPEAT     = 13'd3;

  // First of the unused command codes (5 to 7).
  localparam logic [2:0] CMD_RESERVED = 3'd5;

  typedef enum logic [2:0] {
    SESS_OFF, SESS_POWER_WAIT, SESS_LOADING, SESS_REFRESHING, SESS_POWER_OFF
  } session_e;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} plan_act_e;

  typedef struct {
    plan_act_e   act;
    in_item_t    ev;
    logic [1:0]  reg_idx;
    logic [19:0] value;
  } plan_step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [19:0] cfg_wdata = '0;

  epaper_refresh_sequencer #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES),
    .POWER_TIMEOUT_MS(POWER_TIMEOUT_MS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus plan, filled up front and drained by the driver.
  plan_step_t plan[$];
  int         gen_items = 0;
  logic [12:0] gen_frame = IMAGE_RESET;

  // Register copies as the predictor sees them; owned by the driver.
  logic [7:0]  width_reg;
  logic [12:0] image_reg;
  logic [7:0]  height_reg;
  logic [19:0] timeout_reg;

  // Session state of the predictor; owned by the monitor.
  session_e    sess;
  logic [12:0] rx_count;
  logic [12:0] pwr_ticks;
  logic [6:0]  phase_ticks;
  logic [19:0] refr_ticks;

  out_item_t pending_link[$];
  logic      exp_empty = 1'b1;
  logic      plan_done = 1'b0;
  int        fail_count = 0;
  longint    cycle_count = 0;
  longint    cycle_limit = 64'd10_000_000;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [12:0] frame_of(logic [12:0] n);
    logic [12:0] v;
    v = (n > FRAME_CAP) ? 13'(FRAME_CAP) : n;
    if (v == '0) v = 13'd1;
    return v;
  endfunction

  function automatic void emit(logic [1:0] k, logic [7:0] b, logic [12:0] rep,
                               logic [2:0] st, logic fin);
    out_item_t r;
    r.kind         = k;
    r.out_byte     = b;
    r.repeat_count = rep;
    r.status       = st;
    r.last         = fin;
    pending_link.push_back(r);
  endfunction

  function automatic void emit_cmd(logic [7:0] b);
    emit(KIND_CMD, b, 13'd1, ST_OK, 1'b0);
  endfunction

  function automatic void emit_data(logic [7:0] b);
    emit(KIND_DATA, b, 13'd1, ST_OK, 1'b0);
  endfunction

  function automatic void end_session();
    sess        = SESS_OFF;
    rx_count    = '0;
    pwr_ticks   = '0;
    phase_ticks = '0;
    refr_ticks  = '0;
  endfunction

  // Panel setting, resolution, interval, white fill of the old image, new image.
  function automatic void configure_panel();
    emit_cmd(PCMD_PANEL_SETTING);
    emit_data(PSR_BYTE_0);
    emit_data(PSR_BYTE_1);
    emit_cmd(PCMD_RESOLUTION);
    emit_data(width_reg);
    emit_data(8'h00);
    emit_data(height_reg);
    emit_cmd(PCMD_VCOM_INTERVAL);
    emit_data(VCOM_LOAD_BYTE);
    emit_cmd(PCMD_OLD_IMAGE);
    emit(KIND_DATA, WHITE_BYTE, frame_of(image_reg), ST_OK, 1'b0);
    emit_cmd(PCMD_NEW_IMAGE);
    sess     = SESS_LOADING;
    rx_count = '0;
  endfunction

  function automatic logic [2:0] poll_busy(logic ready);
    emit_cmd(PCMD_GET_STATUS);
    if (ready) begin
      configure_panel();
      return ST_OK;
    end
    if (pwr_ticks >= POWER_TIMEOUT_MS) begin
      end_session();
      return ST_ERR;
    end
    return ST_PEND;
  endfunction

  // Queue the link bytes and the closing status that one event causes.
  function automatic void step_session(in_item_t ev);
    logic [2:0] st;
    st = ST_ERR;
    case (ev.command)
      CMD_BEGIN: begin
        if (sess == SESS_OFF) begin
          emit_cmd(PCMD_BOOSTER);
          emit(KIND_DATA, BOOSTER_BYTE, BOOSTER_REPEAT, ST_OK, 1'b0);
          emit_cmd(PCMD_POWER_ON);
          sess      = SESS_POWER_WAIT;
          rx_count  = '0;
          pwr_ticks = '0;
          st = poll_busy(ev.busy_level);
        end else begin
          end_session();
        end
      end
      CMD_WRITE: begin
        if (sess == SESS_LOADING && rx_count < frame_of(image_reg)) begin
          emit_data(ev.data_byte);
          rx_count = rx_count + 13'd1;
          st = ST_OK;
        end else begin
          end_session();
        end
      end
      CMD_REFRESH: begin
        if (sess == SESS_LOADING && rx_count == frame_of(image_reg)) begin
          emit_cmd(PCMD_REFRESH);
          sess        = SESS_REFRESHING;
          phase_ticks = '0;
          refr_ticks  = '0;
          st = ST_OK;
        end else begin
          end_session();
        end
      end
      CMD_TICK: begin
        case (sess)
          SESS_OFF:     st = ST_IDLE;
          SESS_LOADING: st = ST_OK;
          SESS_POWER_WAIT: begin
            if (pwr_ticks != '1) pwr_ticks = pwr_ticks + 13'd1;
            st = poll_busy(ev.busy_level);
          end
          default: begin
            // Both counters saturate at their widths.
            if (refr_ticks != '1) refr_ticks = refr_ticks + 20'd1;
            if (phase_ticks != '1) phase_ticks = phase_ticks + 7'd1;
            if (refr_ticks >= timeout_reg) begin
              end_session();
              st = ST_ERR;
            end else if (phase_ticks < ((sess == SESS_POWER_OFF) ? POWEROFF_MIN_TICKS
                                                                   : REFRESH_MIN_TICKS)) begin
              st = ST_PEND;
            end else begin
              emit_cmd(PCMD_GET_STATUS);
              if (!ev.busy_level) begin
                st = ST_PEND;
              end else if (sess == SESS_REFRESHING) begin
                emit_cmd(PCMD_VCOM_INTERVAL);
                emit_data(VCOM_SLEEP_BYTE);
                emit_cmd(PCMD_POWER_OFF);
                sess        = SESS_POWER_OFF;
                phase_ticks = '0;
                st = ST_PEND;
              end else begin
                emit_cmd(PCMD_DEEP_SLEEP);
                emit_data(SLEEP_KEY_BYTE);
                end_session();
                st = ST_DONE;
              end
            end
          end
        endcase
      end
      CMD_ABORT: begin
        end_session();
        st = ST_IDLE;
      end
      default: end_session();
    endcase
    emit(KIND_STAT, 8'h00, 13'd1, st, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plan builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void queue_event(logic [2:0] c, logic [7:0] b, logic busy);
    plan_step_t s;
    s.act          = ACT_ITEM;
    s.ev.command   = c;
    s.ev.data_byte = b;
    s.ev.busy_level = busy;
    s.reg_idx      = '0;
    s.value        = '0;
    plan.push_back(s);
    gen_items++;
  endfunction

  function automatic void queue_write_reg(logic [1:0] idx, logic [19:0] v);
    plan_step_t s;
    s.act     = ACT_CFG;
    s.ev      = '0;
    s.reg_idx = idx;
    s.value   = v;
    plan.push_back(s);
    if (idx == CFG_IMAGE) gen_frame = frame_of(v[12:0]);
  endfunction

  function automatic void queue_drain();
    plan_step_t s;
    s.act     = ACT_DRAIN;
    s.ev      = '0;
    s.reg_idx = '0;
    s.value   = '0;
    plan.push_back(s);
  endfunction

  function automatic void queue_noise(int n);
    repeat (n) queue_event(3'($urandom_range(0, 7)), rnd_byte(), rnd_bit());
  endfunction

  // Begin, then poll not ready for a while, then come up ready.
  function automatic void queue_power_up(int not_ready);
    if (not_ready == 0) begin
      queue_event(CMD_BEGIN, rnd_byte(), 1'b1);
    end else begin
      queue_event(CMD_BEGIN, rnd_byte(), 1'b0);
      repeat (not_ready - 1) queue_event(CMD_TICK, rnd_byte(), 1'b0);
      queue_event(CMD_TICK, rnd_byte(), 1'b1);
    end
  endfunction

  // Image writes with the odd idle tick in between.
  function automatic void queue_frame(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) queue_event(CMD_TICK, rnd_byte(), rnd_bit());
      queue_event(CMD_WRITE, rnd_byte(), rnd_bit());
    end
  endfunction

  // Refresh, minimum wait, slow ready, power off, slow ready, deep sleep.
  function automatic void queue_refresh_cycle(int slow_ready, int slow_sleep);
    queue_event(CMD_REFRESH, rnd_byte(), rnd_bit());
    repeat (REFRESH_MIN_TICKS - 1) queue_event(CMD_TICK, rnd_byte(), rnd_bit());
    repeat (slow_ready) queue_event(CMD_TICK, rnd_byte(), 1'b0);
    queue_event(CMD_TICK, rnd_byte(), 1'b1);
    repeat (slow_sleep) queue_event(CMD_TICK, rnd_byte(), 1'b0);
    queue_event(CMD_TICK, rnd_byte(), 1'b1);
  endfunction

  function automatic void queue_random_settings();
    int pick;
    queue_write_reg(CFG_WIDTH, 20'($urandom_range(0, 255)));
    queue_write_reg(CFG_HEIGHT, 20'($urandom_range(0, 255)));
    pick = $urandom_range(0, 9);
    if (pick < 7) queue_write_reg(CFG_IMAGE, 20'($urandom_range(1, 8)));
    else if (pick == 7) queue_write_reg(CFG_IMAGE, 20'd0);
    else queue_write_reg(CFG_IMAGE, 20'($urandom_range(9, 32)));
    pick = $urandom_range(0, 9);
    if (pick < 4) queue_write_reg(CFG_TIMEOUT, 20'($urandom_range(100, 260)));
    else if (pick < 6) queue_write_reg(CFG_TIMEOUT, 20'd40000);
    else if (pick == 6) queue_write_reg(CFG_TIMEOUT, 20'hFFFFF);
    else if (pick == 7) queue_write_reg(CFG_TIMEOUT, 20'd1);
    else if (pick == 8) queue_write_reg(CFG_TIMEOUT, 20'd0);
    else queue_write_reg(CFG_TIMEOUT, 20'($urandom_range(2, 99)));
  endfunction

  // Session that ends early, by abort or by one kind of misuse.
  function automatic void queue_short_session();
    int partial;
    queue_power_up($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: begin
        queue_frame($urandom_range(0, gen_frame));
        queue_event(CMD_ABORT, rnd_byte(), rnd_bit());
      end
      1: begin
        queue_frame(gen_frame);
        queue_event(CMD_WRITE, rnd_byte(), rnd_bit());
      end
      2: begin
        partial = $urandom_range(0, gen_frame - 1);
        queue_frame(partial);
        queue_event(CMD_REFRESH, rnd_byte(), rnd_bit());
      end
      3: begin
        queue_frame(gen_frame);
        queue_event(CMD_BEGIN, rnd_byte(), rnd_bit());
      end
      default: begin
        queue_frame(gen_frame);
        queue_event(CMD_REFRESH, rnd_byte(), rnd_bit());
        repeat ($urandom_range(1, 10)) queue_event(CMD_TICK, rnd_byte(), rnd_bit());
        queue_event(CMD_ABORT, rnd_byte(), rnd_bit());
      end
    endcase
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    // Now and then open a stretch with no idling at all.
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic void flag_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed events from the plan, hold off between transfers, apply
  // register writes only once the link has gone quiet.
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  int in_calm = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    logic        v_next;
    in_item_t    d_next;
    logic        we_next;
    logic [1:0]  addr_next;
    logic [19:0] wdata_next;
    v_next     = in_valid;
    d_next     = in_data;
    we_next    = 1'b0;
    addr_next  = cfg_addr;
    wdata_next = cfg_wdata;
    if (!rst_n) begin
      v_next       = 1'b0;
      in_gap       = 0;
      quiet_cycles = 0;
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      image_reg    = IMAGE_RESET;
      timeout_reg  = TIMEOUT_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        v_next = 1'b0;
        in_gap = draw_wait(in_calm);
      end
      // Count edges with nothing in flight on either channel.
      if (exp_empty && !in_valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (!v_next) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (plan.size() > 0) begin
          case (plan[0].act)
            ACT_ITEM: begin
              v_next = 1'b1;
              d_next = plan[0].ev;
              void'(plan.pop_front());
            end
            ACT_CFG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                we_next    = 1'b1;
                addr_next  = plan[0].reg_idx;
                wdata_next = plan[0].value;
                case (plan[0].reg_idx)
                  CFG_WIDTH:  width_reg   = plan[0].value[7:0];
                  CFG_HEIGHT: height_reg  = plan[0].value[7:0];
                  CFG_IMAGE:  image_reg   = plan[0].value[12:0];
                  default:    timeout_reg = plan[0].value;
                endcase
                void'(plan.pop_front());
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) void'(plan.pop_front());
            end
          endcase
        end
      end
    end
    in_valid  <= v_next;
    in_data   <= d_next;
    cfg_we    <= we_next;
    cfg_addr  <= addr_next;
    cfg_wdata <= wdata_next;
    plan_done <= (plan.size() == 0);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation,
  // predict on each event transfer, and stall the result channel at random.
  // ---------------------------------------------------------------------------
  int out_wait = 0;
  int out_calm = 0;

  always @(posedge clk) begin
    out_item_t want;
    logic      stall_next;
    if (!rst_n) begin
      end_session();
      pending_link.delete();
      out_wait   = 0;
      stall_next = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_link.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $error("result with nothing expected: kind %0d, byte %0h, status %0d",
                   out_data.kind, out_data.out_byte, out_data.status);
        end else begin
          want = pending_link.pop_front();
          flag_field("kind", 32'(want.kind), 32'(out_data.kind));
          flag_field("out_byte", 32'(want.out_byte), 32'(out_data.out_byte));
          flag_field("repeat_count", 32'(want.repeat_count), 32'(out_data.repeat_count));
          flag_field("status", 32'(want.status), 32'(out_data.status));
          flag_field("last", 32'(want.last), 32'(out_data.last));
        end
        out_wait = draw_wait(out_calm);
      end
      if (in_valid && !in_stall) step_session(in_data);
      stall_next = (out_wait > 0);
      if (out_wait > 0) out_wait--;
    end
    out_stall <= stall_next;
    exp_empty <= (pending_link.size() == 0);
  end

  // Watchdog: end the run if the traffic stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int start_items;
    int phase_start;
    int pick;
    int idle_run;

    // Directed: extreme register values, every command, each misuse.
    queue_write_reg(CFG_WIDTH, 20'd0);
    queue_write_reg(CFG_HEIGHT, 20'd255);
    queue_write_reg(CFG_IMAGE, 20'd1);
    queue_write_reg(CFG_TIMEOUT, 20'd0);
    queue_event(CMD_TICK, 8'h00, 1'b0);          // tick while off
    queue_event(CMD_ABORT, 8'hFF, 1'b1);         // abort while off
    queue_event(CMD_WRITE, 8'h5A, 1'b0);         // write outside loading
    queue_event(CMD_REFRESH, 8'h00, 1'b1);       // refresh outside loading
    queue_event(CMD_RESERVED + 3'd2, 8'hFF, 1'b1); // unused command code
    queue_event(CMD_BEGIN, 8'h00, 1'b0);         // first poll not ready
    queue_event(CMD_BEGIN, 8'hFF, 1'b1);         // begin while not off
    queue_event(CMD_BEGIN, 8'h00, 1'b1);         // ready on the first poll
    queue_event(CMD_TICK, 8'hFF, 1'b0);          // tick while loading
    queue_event(CMD_REFRESH, 8'h00, 1'b0);       // frame incomplete
    queue_event(CMD_BEGIN, 8'hA5, 1'b0);
    queue_event(CMD_TICK, 8'h00, 1'b0);          // still waiting for power
    queue_event(CMD_TICK, 8'hFF, 1'b1);          // ready on a tick poll
    queue_event(CMD_WRITE, 8'h00, 1'b0);
    queue_event(CMD_WRITE, 8'hFF, 1'b1);         // write beyond the frame
    queue_event(CMD_BEGIN, 8'h00, 1'b1);
    queue_event(CMD_WRITE, 8'hFF, 1'b0);
    queue_event(CMD_REFRESH, 8'h00, 1'b1);
    queue_event(CMD_TICK, 8'h00, 1'b1);          // zero timeout trips at once
    queue_event(CMD_RESERVED, 8'h00, 1'b0);
    queue_write_reg(CFG_WIDTH, 20'd255);
    queue_write_reg(CFG_HEIGHT, 20'd0);
    queue_write_reg(CFG_IMAGE, 20'h1FFF);        // clamps to the largest frame
    queue_write_reg(CFG_TIMEOUT, 20'hFFFFF);
    queue_event(CMD_BEGIN, 8'h3C, 1'b1);
    queue_event(CMD_ABORT, 8'h00, 1'b0);         // abort while loading
    queue_write_reg(CFG_IMAGE, 20'd0);           // clamps to one byte
    queue_event(CMD_BEGIN, 8'hC3, 1'b1);
    queue_event(CMD_RESERVED + 3'd1, 8'h00, 1'b1);

    // Power wait that never sees ready, left by an abort.
    queue_write_reg(CFG_IMAGE, 20'd4);
    queue_event(CMD_BEGIN, rnd_byte(), 1'b0);
    repeat (3) queue_event(CMD_TICK, rnd_byte(), 1'b0);
    queue_event(CMD_ABORT, rnd_byte(), rnd_bit());

    // One complete session whose slow ready lets the phase counter saturate,
    // then hold the sender until every result is back.
    queue_refresh_cycle(0, 0);
    void'(plan.pop_back());
    repeat (REFRESH_MIN_TICKS) void'(plan.pop_back());
    gen_items = gen_items - REFRESH_MIN_TICKS - 1;
    queue_power_up(2);
    queue_frame(gen_frame);
    queue_refresh_cycle(40, 3);
    queue_drain();

    // Random: sessions cut short by abort or misuse, and noise.
    start_items = gen_items;
    phase_start = gen_items;
    queue_random_settings();
    while (gen_items - start_items < RANDOM_ITEMS) begin
      if (gen_items - phase_start >= PHASE_ITEMS) begin
        phase_start = gen_items;
        if ($urandom_range(0, 2) == 0) queue_drain();
        queue_random_settings();
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        queue_short_session();
      end else begin
        queue_noise($urandom_range(2, 6));
      end
    end

    // Slowest correct run, several times over.
    cycle_limit = longint'(plan.size()) *
                  (MAX_RESULTS * (WAIT_MAX + 1) + WAIT_MAX + 1 + SETTLE_CYCLES) * 4 + 20000;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (!plan_done || in_valid) @(posedge clk);
    idle_run = 0;
    while (idle_run < END_QUIET) begin
      @(posedge clk);
      idle_run = exp_empty ? idle_run + 1 : 0;
    end
    @(negedge clk);
    if (fail_count == 0 && pending_link.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/eprs_pkg.sv
sv/eprs_ctrl.sv
sv/eprs_emit.sv
sv/epaper_refresh_sequencer.sv
dv/tb.sv
